>>> hw/rtl/rms_env_pkg.sv
// ---------------------------------------------------------------------------
// RMS envelope package
// Shared constants, payload types and the back-end state encoding.
// ---------------------------------------------------------------------------
package rms_env_pkg;

  localparam int MAX_WINDOW = 19200;
  localparam int SLOTS      = 3;
  localparam int SLOT_W     = 2;
  localparam int SUM_W      = 45;
  localparam int FILL_W     = 15;
  localparam int RATE_W     = 18;
  localparam int SQ_W       = 31;
  localparam int RMS_W      = 16;
  localparam int RESET_RATE = 48000;
  // floor(x/10) == (x * RECIP) >> RECIP_SHIFT for every 18-bit x
  localparam int RECIP       = 838861;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 23;
  localparam int MIN_WINDOW  = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CNT_W       = 6;
  localparam int MEAN_W      = 32;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_stream;
  } rms_in_t;

  typedef struct packed {
    logic [RMS_W-1:0]  rms;
    logic [FILL_W-1:0] window_fill;
    logic              last;
  } rms_out_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic              last;
  } rms_close_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } rms_q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } rms_bk_state_t;

endpackage

>>> hw/rtl/rms_front.sv
// ---------------------------------------------------------------------------
// RMS envelope front end
// Opens windows, accumulates squared samples and queues closed windows.
// ---------------------------------------------------------------------------
module rms_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rms_env_pkg::RATE_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rms_env_pkg::rms_in_t           in_data,
  input  logic                           q_full,
  output logic                           q_push,
  output rms_env_pkg::rms_close_t        q_data
);
  import rms_env_pkg::*;

  logic [FILL_W-1:0] win_r, hop_r, phase_r, phase_nxt;
  logic [SUM_W-1:0]  sum_r  [SLOTS];
  logic [FILL_W-1:0] fill_r [SLOTS];
  logic [SUM_W-1:0]  sum_nxt  [SLOTS];
  logic [FILL_W-1:0] fill_nxt [SLOTS];
  logic [SLOTS-1:0]  open_r, open_nxt, pend_r, pend_nxt;
  logic              eos_r;
  logic              accept;
  logic [RATE_W+RECIP_W-1:0] prod;
  logic [RATE_W+RECIP_W-RECIP_SHIFT-1:0] quot;
  logic [FILL_W-1:0] win_new;
  logic signed [31:0] sq_s;
  logic [SQ_W-1:0]   sq;
  logic              opened;
  logic [SLOT_W-1:0] pick;
  logic [1:0]        pend_cnt;
  logic [FILL_W:0]   phase_inc;

  assign prod = RATE_W'(cfg_wdata) * RECIP_W'(RECIP);
  assign quot = prod[RATE_W+RECIP_W-1:RECIP_SHIFT];

  always_comb begin
    if (quot < MIN_WINDOW) begin
      win_new = FILL_W'(MIN_WINDOW);
    end else if (quot > MAX_WINDOW) begin
      win_new = FILL_W'(MAX_WINDOW);
    end else begin
      win_new = quot[FILL_W-1:0];
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (pend_r != '0);
  assign sq_s     = in_data.sample * in_data.sample;
  assign sq       = sq_s[SQ_W-1:0];

  // open a slot at hop start, then add the sample to every open window
  always_comb begin
    opened   = 1'b0;
    open_nxt = open_r;
    pend_nxt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sum_nxt[i]  = sum_r[i];
      fill_nxt[i] = fill_r[i];
      if (phase_r == '0 && !opened && !open_r[i]) begin
        opened      = 1'b1;
        open_nxt[i] = 1'b1;
        sum_nxt[i]  = '0;
        fill_nxt[i] = '0;
      end
      if (open_nxt[i]) begin
        sum_nxt[i] = sum_nxt[i] + SUM_W'(sq);
        if (fill_nxt[i] < MAX_WINDOW) begin
          fill_nxt[i] = fill_nxt[i] + 1'b1;
        end
        pend_nxt[i] = in_data.end_of_stream || (fill_nxt[i] >= win_r);
      end
    end
  end

  assign phase_inc = {1'b0, phase_r} + 1'b1;

  always_comb begin
    if (in_data.end_of_stream || phase_inc >= {1'b0, hop_r}) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_inc[FILL_W-1:0];
    end
  end

  // drain closed windows, largest fill (earliest start) first
  always_comb begin
    pick = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pend_r[i] && (!pend_r[pick] || fill_r[i] > fill_r[pick])) begin
        pick = SLOT_W'(i);
      end
    end
  end

  assign pend_cnt    = 2'(pend_r[0]) + 2'(pend_r[1]) + 2'(pend_r[2]);
  assign q_push      = (pend_r != '0) && !q_full;
  assign q_data.sum  = sum_r[pick];
  assign q_data.fill = fill_r[pick];
  assign q_data.last = eos_r && (pend_cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= FILL_W'(RESET_RATE / 10);
      hop_r   <= FILL_W'(RESET_RATE / 20);
      phase_r <= '0;
      open_r  <= '0;
      pend_r  <= '0;
      eos_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_r <= win_new;
        hop_r <= win_new >> 1;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        open_r  <= open_nxt;
        pend_r  <= pend_nxt;
        eos_r   <= in_data.end_of_stream;
      end else if (q_push) begin
        open_r[pick] <= 1'b0;
        pend_r[pick] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < SLOTS; i++) begin
        sum_r[i]  <= sum_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

endmodule

>>> hw/rtl/rms_fifo.sv
// ---------------------------------------------------------------------------
// RMS envelope close queue
// Short register queue of closed windows between front and back end.
// ---------------------------------------------------------------------------
module rms_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rms_env_pkg::rms_close_t push_data,
  input  logic                    pop,
  output rms_env_pkg::rms_close_t pop_data,
  output rms_env_pkg::rms_q_stat_t stat
);
  import rms_env_pkg::*;

  rms_close_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

>>> hw/rtl/rms_back.sv
// ---------------------------------------------------------------------------
// RMS envelope back end
// Divides a window sum by its fill, takes the integer root, holds the result.
// ---------------------------------------------------------------------------
module rms_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rms_env_pkg::rms_q_stat_t q_stat,
  input  rms_env_pkg::rms_close_t  q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output rms_env_pkg::rms_out_t    out_data
);
  import rms_env_pkg::*;

  rms_bk_state_t     state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  dq_r;
  logic [FILL_W-1:0] rem_r, div_r;
  logic              last_r;
  logic [MEAN_W-1:0] val_r;
  logic [17:0]       sr_r;
  logic [RMS_W-1:0]  root_r;
  logic              ov_r;
  rms_out_t          od_r;
  logic [FILL_W:0]   dtrial;
  logic              dge;
  logic [19:0]       strial, stest;
  logic              sge;
  logic              load, div_step, sqrt_step, sqrt_load, out_load, out_free;

  assign out_free  = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign dtrial = {rem_r, dq_r[SUM_W-1]};
  assign dge    = dtrial >= {1'b0, div_r};
  assign strial = {sr_r, val_r[MEAN_W-1 -: 2]};
  assign stest  = {2'b00, root_r, 2'b01};
  assign sge    = strial >= stest;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat.empty) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == CNT_W'(SUM_W - 1)) state_nxt = BK_SQRT;
      BK_SQRT: if (cnt_r == CNT_W'(RMS_W - 1)) state_nxt = BK_DONE;
      BK_DONE: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0; div_step = 1'b0; sqrt_step = 1'b0; sqrt_load = 1'b0; out_load = 1'b0;
    unique case (state_r)
      BK_IDLE: load = !q_stat.empty;
      BK_DIV: begin
        div_step  = 1'b1;
        sqrt_load = (cnt_r == CNT_W'(SUM_W - 1));
      end
      BK_SQRT: sqrt_step = 1'b1;
      BK_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load || sqrt_load || (sqrt_step && state_nxt != BK_SQRT)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r   <= q_data.sum;
      div_r  <= q_data.fill;
      rem_r  <= '0;
      last_r <= q_data.last;
    end
    if (div_step) begin
      rem_r <= dge ? FILL_W'(dtrial - {1'b0, div_r}) : dtrial[FILL_W-1:0];
      dq_r  <= {dq_r[SUM_W-2:0], dge};
    end
    if (sqrt_load) begin
      // mean never exceeds 2^30, so the low quotient bits hold it whole
      val_r  <= {dq_r[MEAN_W-2:0], dge};
      sr_r   <= '0;
      root_r <= '0;
    end
    if (sqrt_step) begin
      sr_r   <= sge ? 18'(strial - stest) : strial[17:0];
      root_r <= {root_r[RMS_W-2:0], sge};
      val_r  <= val_r << 2;
    end
    if (out_load) begin
      od_r.rms         <= root_r;
      od_r.window_fill <= div_r;
      od_r.last        <= last_r;
    end
  end

endmodule

>>> hw/rtl/windowed_rms_envelope.sv
// ---------------------------------------------------------------------------
// Windowed RMS envelope
// Half-overlapping short-time RMS of a Q15 sample stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request per sample (sample, end_of_stream), valid/stall.
//   out_* : one request per closed window (rms, window_fill, last).
//   cfg_* : write sample_rate; window = rate/10 (2..19200), hop = window/2.
//           Write only while the block is idle.
// Throughput: a sample is taken every cycle while no window is closing.
//   A sample that closes k windows (k = 0..3) holds the input while
//   the front end queues them, earliest start first, one per cycle
//   while the queue has room. The back end pops a closed window, runs it
//   through the bit-serial divider and then the root unit, and loads
//   the result into the output register. It takes one window at a time,
//   the next only once the result is loaded; a four-deep queue
//   decouples it from the front end.
// Reset (rst_n low, synchronous): rate returns to 48000, all windows close,
//   hop phase returns to zero, queue and output register empty.
// A stalled out_stall holds the result; the back end and the queue then
//   fill, and in the end in_stall rises. Nothing is dropped.
// ---------------------------------------------------------------------------
module windowed_rms_envelope (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rms_env_pkg::RATE_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rms_env_pkg::rms_in_t           in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rms_env_pkg::rms_out_t          out_data
);
  import rms_env_pkg::*;

  rms_close_t  push_data, pop_data;
  rms_q_stat_t q_stat;
  logic        q_push, q_pop;

  // front: windowing and accumulation
  rms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // queue of closed windows
  rms_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .pop      (q_pop),
    .pop_data (pop_data),
    .stat     (q_stat)
  );

  // back: mean and root
  rms_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (pop_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.window_fill != '0)
    else $error("closed window reported with zero fill");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rms <= 16'd32768)
    else $error("rms above full scale");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("close queue overrun");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty close queue");

endmodule
